FILE: src/toeq_pkg.sv
// ----------------------------------------------------------------------------
// toeq_pkg: shared types and codes of the time-ordered event queue
// Holds the request, result and slot entry layouts and the status codes.
// ----------------------------------------------------------------------------
package toeq_pkg;

  localparam int OCC_W = 5;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // one stored event: 56 bits
  typedef struct packed {
    logic        [7:0]  kind;
    logic signed [15:0] action;
    logic        [31:0] due;
  } evt_t;

  typedef struct packed {
    logic               req_type;
    logic        [7:0]  event_kind;
    logic signed [15:0] event_action;
    logic        [31:0] event_due;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic        [7:0]    popped_kind;
    logic signed [15:0]   popped_action;
    logic        [31:0]   popped_due;
    logic                 head_valid;
    logic        [7:0]    head_kind;
    logic signed [15:0]   head_action;
    logic        [31:0]   head_due;
    logic [OCC_W-1:0]     occupancy;
  } res_t;

endpackage

FILE: src/toeq_slot_ram.sv
// ----------------------------------------------------------------------------
// toeq_slot_ram: event slot storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module toeq_slot_ram import toeq_pkg::*; #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  evt_t              wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output evt_t              rd_data
);

  evt_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: src/time_ordered_event_queue_unit.sv
// ----------------------------------------------------------------------------
// time_ordered_event_queue_unit: bounded event queue kept sorted by due time
// Insert: walks down from the first free slot past the k stored events later
//   than the new one (at most QUEUE_DEPTH - 1); one slot moved per cycle.
// Remove of n >= 2 events: shift-down walk over the slot RAM.
// Full insert, empty remove, remove of the last event: result next cycle.
// busy drops in the strobe cycle; the next request may start there.
// Reset (rst, synchronous) empties the queue; slot contents are not cleared.
// ----------------------------------------------------------------------------
module time_ordered_event_queue_unit import toeq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output res_t result
);

  localparam int ADDR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_WALK  = 3'b010,
    S_SHIFT = 3'b100
  } state_t;

  state_t            state, state_next;
  logic [ADDR_W-1:0] idx, idx_next;
  logic [CNT_W-1:0]  count, count_next;
  evt_t              head, head_next;
  evt_t              pend, pend_next;
  res_t              res, res_next;
  logic              done_next;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  evt_t              wr_data;
  logic [ADDR_W-1:0] rd_addr;
  evt_t              rd_data;

  toeq_slot_ram #(
    .DEPTH (QUEUE_DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy   = (state != S_IDLE);
  assign result = res;

  // Sequencer. The slot RAM read data always belongs to the address issued
  // in the cycle before, so every walk step compares or moves one slot while
  // the read of the next one is already under way.
  always_comb begin
    state_next = state;
    idx_next   = idx;
    count_next = count;
    head_next  = head;
    pend_next  = pend;
    res_next   = res;
    done_next  = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = idx;
    wr_data    = pend;
    rd_addr    = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          // popped fields are zero unless a remove succeeds
          res_next.popped_kind   = '0;
          res_next.popped_action = '0;
          res_next.popped_due    = '0;
          if (req.req_type == REQ_INSERT) begin
            pend_next.kind   = req.event_kind;
            pend_next.action = req.event_action;
            pend_next.due    = req.event_due;
            if (count == CNT_W'(QUEUE_DEPTH)) begin
              // reject: queue unchanged, head still valid
              res_next.status      = ST_FULL;
              res_next.head_valid  = 1'b1;
              res_next.head_kind   = head.kind;
              res_next.head_action = head.action;
              res_next.head_due    = head.due;
              res_next.occupancy   = OCC_W'(count);
              done_next            = 1'b1;
            end else begin
              // walk down from the first free slot
              idx_next = ADDR_W'(count);
              if (count != '0) begin
                rd_addr = ADDR_W'(count - CNT_W'(1));
              end
              state_next = S_WALK;
            end
          end else begin
            if (count == '0) begin
              res_next.status      = ST_EMPTY;
              res_next.head_valid  = 1'b0;
              res_next.head_kind   = '0;
              res_next.head_action = '0;
              res_next.head_due    = '0;
              res_next.occupancy   = '0;
              done_next            = 1'b1;
            end else begin
              res_next.popped_kind   = head.kind;
              res_next.popped_action = head.action;
              res_next.popped_due    = head.due;
              if (count == CNT_W'(1)) begin
                // last event leaves: nothing to shift
                count_next           = '0;
                res_next.status      = ST_OK;
                res_next.head_valid  = 1'b0;
                res_next.head_kind   = '0;
                res_next.head_action = '0;
                res_next.head_due    = '0;
                res_next.occupancy   = '0;
                done_next            = 1'b1;
              end else begin
                // start the shift-down with slot one
                rd_addr    = ADDR_W'(1);
                idx_next   = ADDR_W'(1);
                state_next = S_SHIFT;
              end
            end
          end
        end
      end

      S_WALK: begin
        wr_en   = 1'b1;
        wr_addr = idx;
        if ((idx == '0) || (rd_data.due <= pend.due)) begin
          // slot zero reached, or slot below is earlier or equal: place the new event here
          wr_data = pend;
          if (idx == '0) begin
            head_next = pend;
          end
          count_next           = count + CNT_W'(1);
          res_next.status      = ST_OK;
          res_next.head_valid  = 1'b1;
          res_next.head_kind   = head_next.kind;
          res_next.head_action = head_next.action;
          res_next.head_due    = head_next.due;
          res_next.occupancy   = OCC_W'(count + CNT_W'(1));
          done_next            = 1'b1;
          state_next           = S_IDLE;
        end else begin
          // later event: move it up one slot and look further down
          wr_data  = rd_data;
          idx_next = idx - ADDR_W'(1);
          if (idx >= ADDR_W'(2)) begin
            rd_addr = idx - ADDR_W'(2);
          end
        end
      end

      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = idx - ADDR_W'(1);
        wr_data = rd_data;
        if (idx == ADDR_W'(1)) begin
          head_next = rd_data;
        end
        if (CNT_W'(idx) + CNT_W'(1) == count) begin
          count_next           = count - CNT_W'(1);
          res_next.status      = ST_OK;
          res_next.head_valid  = 1'b1;
          res_next.head_kind   = head_next.kind;
          res_next.head_action = head_next.action;
          res_next.head_due    = head_next.due;
          res_next.occupancy   = OCC_W'(count - CNT_W'(1));
          done_next            = 1'b1;
          state_next           = S_IDLE;
        end else begin
          rd_addr  = idx + ADDR_W'(1);
          idx_next = idx + ADDR_W'(1);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  // Payload: hold the walk index, the head copy, the pending event and the result
  always_ff @(posedge clk) begin
    idx  <= idx_next;
    head <= head_next;
    pend <= pend_next;
    res  <= res_next;
  end

endmodule
